// ===== design/efa_pkg.sv =====
package efa_pkg;

  // Field widths
  localparam int GRID_W   = 18;
  localparam int LOAD_W   = 17;
  localparam int IVL_W    = 16;
  localparam int HOUR_W   = 5;
  localparam int DAY_W    = 16;
  localparam int THR_W    = 16;
  localparam int ENERGY_W = 48;
  localparam int SECS_W   = 17;
  localparam int REM_W    = 10;
  localparam int QUO_W    = 7;

  // Hourly bins
  localparam int HOURS      = 24;
  localparam int HOUR_IDX_W = (HOURS > 1) ? $clog2(HOURS) : 1;

  // Stream word widths
  localparam int IN_W  = 80;
  localparam int OUT_W = 312;

  // Constants
  localparam logic signed [GRID_W-1:0] DROP_LIMIT = -18'sd90000;
  localparam logic [THR_W-1:0]  THR_RESET   = 16'd10;
  localparam logic [SECS_W-1:0] SECS_MAX    = 17'h1FFFF;
  localparam int                MS_PER_S    = 1000;
  // floor(ivl / 1000) == (ivl * RECIP) >> RECIP_SHIFT for every 16-bit ivl
  localparam logic [16:0]       RECIP       = 17'd67109;
  localparam int                RECIP_SHIFT = 26;

  typedef logic [ENERGY_W-1:0] energy_t;

  typedef struct packed {
    energy_t imp;
    energy_t exp;
    energy_t red;
  } bin_t;

  // Update request from the accumulator stage to the hourly bin store
  typedef struct packed {
    logic              upd;
    logic              fresh;
    logic [HOUR_W-1:0] hour;
    bin_t              add;
  } bin_req_t;

  function automatic energy_t sat_add(energy_t a, energy_t b);
    logic [ENERGY_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[ENERGY_W] ? {ENERGY_W{1'b1}} : sum[ENERGY_W-1:0];
  endfunction

endpackage

// ===== design/efa_hour_bins.sv =====
module efa_hour_bins (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    rd_en,
  input  logic [efa_pkg::HOUR_W-1:0] rd_hour,
  input  efa_pkg::bin_req_t       req,
  output efa_pkg::bin_t           bin_o
);

  localparam int IW = efa_pkg::HOUR_IDX_W;

  efa_pkg::bin_t                mem [efa_pkg::HOURS];
  efa_pkg::bin_t                rdata_r;
  logic [efa_pkg::HOURS-1:0]    hour_valid_r, hour_valid_nxt;
  logic                         last_wr_valid_r;
  logic [IW-1:0]                last_wr_hour_r;
  efa_pkg::bin_t                last_wr_data_r;

  logic          rd_in_range, in_range, hit, fwd, wr_en;
  logic [IW-1:0] rd_idx, idx;
  efa_pkg::bin_t old_bin, new_bin;

  assign rd_in_range = {1'b0, rd_hour} < (efa_pkg::HOUR_W + 1)'(efa_pkg::HOURS);
  assign rd_idx      = rd_hour[IW-1:0];
  assign in_range    = {1'b0, req.hour} < (efa_pkg::HOUR_W + 1)'(efa_pkg::HOURS);
  assign idx         = req.hour[IW-1:0];

  // Pick the newest copy: the last write may have landed as this entry was read
  assign fwd = last_wr_valid_r && (last_wr_hour_r == idx);
  assign hit = in_range && !req.fresh && hour_valid_r[idx];

  always_comb begin
    if (!hit) begin
      old_bin = '0;
    end else if (fwd) begin
      old_bin = last_wr_data_r;
    end else begin
      old_bin = rdata_r;
    end
    new_bin.imp = efa_pkg::sat_add(old_bin.imp, req.add.imp);
    new_bin.exp = efa_pkg::sat_add(old_bin.exp, req.add.exp);
    new_bin.red = efa_pkg::sat_add(old_bin.red, req.add.red);
  end

  assign bin_o = in_range ? new_bin : '0;
  assign wr_en = req.upd && in_range;

  // Clear all valid bits on a new day, then mark the written hour
  always_comb begin
    hour_valid_nxt = hour_valid_r;
    if (req.upd) begin
      if (req.fresh) begin
        hour_valid_nxt = '0;
      end
      if (in_range) begin
        hour_valid_nxt = hour_valid_nxt | (efa_pkg::HOURS'(1) << idx);
      end
    end
  end

  // Bin memory: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx] <= new_bin;
    end
    if (rd_en && rd_in_range) begin
      rdata_r <= mem[rd_idx];
    end
  end

  // Track valid bits and the last write for forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_valid_r    <= '0;
      last_wr_valid_r <= 1'b0;
    end else begin
      hour_valid_r <= hour_valid_nxt;
      if (wr_en) begin
        last_wr_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_wr_hour_r <= idx;
      last_wr_data_r <= new_bin;
    end
  end

  a_written_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> hour_valid_r[$past(idx)])
    else $error("written hour bin not marked valid");

  a_forward_matches_mem: assert property (@(posedge clk) disable iff (!rst_n)
    last_wr_valid_r |-> mem[last_wr_hour_r] == last_wr_data_r)
    else $error("forwarding copy differs from bin memory");

  a_new_day_clears: assert property (@(posedge clk) disable iff (!rst_n)
    req.upd && req.fresh |=> $countones(hour_valid_r) <= 1)
    else $error("hour valid bits not cleared on new day");

endmodule

// ===== design/energy_flow_accumulator_top.sv =====
// Daily energy accumulator for a power diverter.
// in_*  : one power sample per word; tdata from bit 0 up: grid_power, load_power,
//         interval_ms, night, load_measured, hour_of_day, day_number, time_valid.
// out_* : one result word per kept sample; dropped samples (grid power below
//         -90000 W or time_valid low) give no word.
// cfg_* : cfg_wr_en writes active_power_threshold from cfg_wr_data; write only
//         while no sample is in flight.
// Pipeline: a result word shows on out_tvalid after the sample, power and energy
//         registers, then the output register loaded by the update stage.
// Throughput: one sample per cycle while the output is not stalled. Bins live
//         in a single-port-write memory with registered read; a bin is read in
//         stage 2, and the update stage adds and writes it back. The last write
//         is forwarded to a sample that follows at once.
// Reset: totals, seconds, remainder, day and all hour valid bits clear at once;
//         the first kept sample starts a new day. The threshold returns to 10.
// Stall: while out_tvalid is high and out_tready low the whole pipeline holds
//         and in_tready is low; nothing is lost or repeated.
module energy_flow_accumulator_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [efa_pkg::THR_W-1:0]  cfg_wr_data,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // grid_power, load_power, interval_ms, night, load_measured, hour_of_day,
  // day_number, time_valid (bit 0 up), zero fill
  input  logic [efa_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // import_total, export_total, redirect_total, active_seconds, hour_import,
  // hour_export, hour_redirect, new_day (bit 0 up), zero fill
  output logic [efa_pkg::OUT_W-1:0]  out_tdata
);

  localparam int GW = efa_pkg::GRID_W;
  localparam int LW = efa_pkg::LOAD_W;
  localparam int VW = efa_pkg::IVL_W;
  localparam int HW = efa_pkg::HOUR_W;
  localparam int DW = efa_pkg::DAY_W;
  localparam int EW = efa_pkg::ENERGY_W;
  localparam int SW = efa_pkg::SECS_W;
  localparam int RW = efa_pkg::REM_W;
  localparam int QW = efa_pkg::QUO_W;

  logic advance;

  // Stage 1: raw fields
  logic                 p1_valid_r;
  logic signed [GW-1:0] p1_grid_r;
  logic [LW-1:0]        p1_load_r;
  logic [VW-1:0]        p1_ivl_r;
  logic                 p1_night_r, p1_meas_r, p1_tvalid_r;
  logic [HW-1:0]        p1_hour_r;
  logic [DW-1:0]        p1_day_r;

  // Stage 2: filtered, powers and whole seconds of the interval
  logic                 p2_valid_r, p2_pos_r;
  logic [GW-1:0]        p2_gabs_r;
  logic [LW-1:0]        p2_redir_r, p2_load_r;
  logic [VW-1:0]        p2_ivl_r;
  logic [QW-1:0]        p2_quo_r;
  logic [HW-1:0]        p2_hour_r;
  logic [DW-1:0]        p2_day_r;

  // Stage 3: energies
  logic                 p3_valid_r, p3_pos_r;
  logic [GW+VW-1:0]     p3_egrid_r;
  logic [LW+VW-1:0]     p3_ered_r;
  logic [QW-1:0]        p3_quo_r;
  logic [RW-1:0]        p3_rem_r;
  logic [LW-1:0]        p3_load_r;
  logic [HW-1:0]        p3_hour_r;
  logic [DW-1:0]        p3_day_r;

  // Day state
  logic [efa_pkg::THR_W-1:0] thr_r;
  efa_pkg::energy_t     import_sum_r, export_sum_r, redirect_sum_r;
  efa_pkg::energy_t     import_sum_nxt, export_sum_nxt, redirect_sum_nxt;
  logic [SW-1:0]        active_secs_r, active_secs_nxt;
  logic [RW-1:0]        ms_rem_r, ms_rem_nxt;
  logic [DW-1:0]        current_day_r;
  logic                 day_seen_r;

  logic                 out_valid_r;
  logic [efa_pkg::OUT_W-1:0] out_data_r;

  // Stage 1 combinational
  logic                 p1_keep, p1_pos;
  logic [GW-1:0]        p1_gabs, p1_gimp;
  logic [LW-1:0]        p1_redir;
  logic [VW+17-1:0]     p1_recip_prod;

  // Stage 2 combinational
  logic [GW+VW-1:0]     p2_egrid;
  logic [LW+VW-1:0]     p2_ered;
  logic [VW-1:0]        p2_quo_ms;
  logic [RW-1:0]        p2_rem;

  // Stage 3 combinational
  logic                 upd, fresh, active, carry;
  efa_pkg::energy_t     e_grid, e_red, base_imp, base_exp, base_red;
  logic [SW-1:0]        base_secs;
  logic [RW-1:0]        base_rem;
  logic [RW:0]          rem_sum;
  logic [QW:0]          whole;
  logic [SW:0]          secs_sum;
  efa_pkg::bin_req_t    bin_req;
  efa_pkg::bin_t        bin_res;

  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= efa_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // Capture the incoming word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (advance) begin
      p1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1_grid_r   <= $signed(in_tdata[17:0]);
      p1_load_r   <= in_tdata[34:18];
      p1_ivl_r    <= in_tdata[50:35];
      p1_night_r  <= in_tdata[51];
      p1_meas_r   <= in_tdata[52];
      p1_hour_r   <= in_tdata[57:53];
      p1_day_r    <= in_tdata[73:58];
      p1_tvalid_r <= in_tdata[74];
    end
  end

  // Drop bad samples, derive redirect power and whole seconds of the interval
  assign p1_keep  = p1_tvalid_r && !(p1_grid_r < efa_pkg::DROP_LIMIT);
  assign p1_pos   = p1_grid_r > $signed(GW'(0));
  assign p1_gabs  = p1_pos ? p1_grid_r : GW'(-p1_grid_r);
  assign p1_gimp  = p1_pos ? p1_gabs : '0;

  always_comb begin
    if (p1_night_r) begin
      p1_redir = '0;
    end else if (p1_meas_r) begin
      p1_redir = p1_load_r;
    end else if ({1'b0, p1_load_r} > p1_gimp) begin
      p1_redir = LW'({1'b0, p1_load_r} - p1_gimp);
    end else begin
      p1_redir = '0;
    end
  end

  assign p1_recip_prod = p1_ivl_r * efa_pkg::RECIP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
    end else if (advance) begin
      p2_valid_r <= p1_valid_r && p1_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p2_pos_r   <= p1_pos;
      p2_gabs_r  <= p1_gabs;
      p2_redir_r <= p1_redir;
      p2_load_r  <= p1_load_r;
      p2_ivl_r   <= p1_ivl_r;
      p2_quo_r   <= p1_recip_prod[efa_pkg::RECIP_SHIFT +: QW];
      p2_hour_r  <= p1_hour_r;
      p2_day_r   <= p1_day_r;
    end
  end

  // Form energies and the millisecond part of the interval
  assign p2_egrid  = p2_gabs_r * p2_ivl_r;
  assign p2_ered   = p2_redir_r * p2_ivl_r;
  assign p2_quo_ms = VW'(p2_quo_r * VW'(efa_pkg::MS_PER_S));
  assign p2_rem    = RW'(p2_ivl_r - p2_quo_ms);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_valid_r <= 1'b0;
    end else if (advance) begin
      p3_valid_r <= p2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p3_pos_r   <= p2_pos_r;
      p3_egrid_r <= p2_egrid;
      p3_ered_r  <= p2_ered;
      p3_quo_r   <= p2_quo_r;
      p3_rem_r   <= p2_rem;
      p3_load_r  <= p2_load_r;
      p3_hour_r  <= p2_hour_r;
      p3_day_r   <= p2_day_r;
    end
  end

  // Update stage: day rollover, totals and active time
  assign upd    = advance && p3_valid_r;
  assign fresh  = !day_seen_r || (p3_day_r != current_day_r);
  assign e_grid = EW'(p3_egrid_r);
  assign e_red  = EW'(p3_ered_r);

  assign base_imp  = fresh ? '0 : import_sum_r;
  assign base_exp  = fresh ? '0 : export_sum_r;
  assign base_red  = fresh ? '0 : redirect_sum_r;
  assign base_secs = fresh ? '0 : active_secs_r;
  assign base_rem  = fresh ? '0 : ms_rem_r;

  assign import_sum_nxt   = p3_pos_r ? efa_pkg::sat_add(base_imp, e_grid) : base_imp;
  assign export_sum_nxt   = p3_pos_r ? base_exp : efa_pkg::sat_add(base_exp, e_grid);
  assign redirect_sum_nxt = efa_pkg::sat_add(base_red, e_red);

  assign active   = p3_load_r > {1'b0, thr_r};
  assign rem_sum  = {1'b0, base_rem} + {1'b0, p3_rem_r};
  assign carry    = rem_sum >= (RW + 1)'(efa_pkg::MS_PER_S);
  assign whole    = {1'b0, p3_quo_r} + (QW + 1)'(carry);
  assign secs_sum = {1'b0, base_secs} + (SW + 1)'(whole);

  always_comb begin
    if (active) begin
      ms_rem_nxt      = carry ? RW'(rem_sum - (RW + 1)'(efa_pkg::MS_PER_S)) : RW'(rem_sum);
      active_secs_nxt = secs_sum[SW] ? efa_pkg::SECS_MAX : secs_sum[SW-1:0];
    end else begin
      ms_rem_nxt      = base_rem;
      active_secs_nxt = base_secs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      import_sum_r   <= '0;
      export_sum_r   <= '0;
      redirect_sum_r <= '0;
      active_secs_r  <= '0;
      ms_rem_r       <= '0;
      current_day_r  <= '0;
      day_seen_r     <= 1'b0;
    end else if (upd) begin
      import_sum_r   <= import_sum_nxt;
      export_sum_r   <= export_sum_nxt;
      redirect_sum_r <= redirect_sum_nxt;
      active_secs_r  <= active_secs_nxt;
      ms_rem_r       <= ms_rem_nxt;
      current_day_r  <= p3_day_r;
      day_seen_r     <= 1'b1;
    end
  end

  // Hourly bins: read in stage 2, add and write back in stage 3
  always_comb begin
    bin_req.upd     = upd;
    bin_req.fresh   = fresh;
    bin_req.hour    = p3_hour_r;
    bin_req.add.imp = p3_pos_r ? e_grid : '0;
    bin_req.add.exp = p3_pos_r ? '0 : e_grid;
    bin_req.add.red = e_red;
  end

  efa_hour_bins u_bins (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (advance),
    .rd_hour (p2_hour_r),
    .req     (bin_req),
    .bin_o   (bin_res)
  );

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= p3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      out_data_r <= {6'b0, fresh, bin_res.red, bin_res.exp, bin_res.imp,
                     active_secs_nxt, redirect_sum_nxt, export_sum_nxt, import_sum_nxt};
    end
  end

  a_rem_below_second: assert property (@(posedge clk) disable iff (!rst_n)
    ms_rem_r < RW'(efa_pkg::MS_PER_S))
    else $error("millisecond remainder reached one second");

  a_secs_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    upd && !fresh |=> active_secs_r >= $past(active_secs_r))
    else $error("active seconds fell within a day");

  a_day_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    upd |=> day_seen_r && (current_day_r == $past(p3_day_r)))
    else $error("current day not taken from the last sample");

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import efa_pkg::*;

  localparam int IN_PAD_W    = IN_W - (GRID_W + LOAD_W + IVL_W + 2 + HOUR_W + DAY_W + 1);
  localparam int OUT_PAD_W   = OUT_W - (6 * ENERGY_W + SECS_W + 1);
  localparam int STALL_LIMIT = 2000;
  localparam int PRINT_LIMIT = 40;
  localparam logic [64:0] E_TOP = (65'd1 << ENERGY_W) - 65'd1;

  // One sample word, lowest field last
  typedef struct packed {
    logic [IN_PAD_W-1:0]      pad;
    logic                     time_ok;
    logic [DAY_W-1:0]         day;
    logic [HOUR_W-1:0]        hour;
    logic                     measured;
    logic                     night;
    logic [IVL_W-1:0]         ivl;
    logic [LOAD_W-1:0]        load;
    logic signed [GRID_W-1:0] grid;
  } sample_t;

  // One result word, lowest field last
  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic                 new_day;
    energy_t              hour_redirect;
    energy_t              hour_export;
    energy_t              hour_import;
    logic [SECS_W-1:0]    secs;
    energy_t              redirect_wms;
    energy_t              export_wms;
    energy_t              import_wms;
  } tally_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [THR_W-1:0]  cfg_wr_data = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;

  // Expected result words, oldest first
  tally_t pending_totals [$];

  // Running copy of the day's bookkeeping
  logic [THR_W-1:0]  thr_now = THR_RESET;
  energy_t           day_import = '0;
  energy_t           day_export = '0;
  energy_t           day_redirect = '0;
  logic [SECS_W-1:0] day_secs = '0;
  int unsigned       ms_carry = 0;
  energy_t           bin_imp [HOURS];
  energy_t           bin_exp [HOURS];
  energy_t           bin_red [HOURS];
  logic [HOURS-1:0]  bin_live = '0;
  logic [DAY_W-1:0]  day_now = '0;
  bit                day_known = 1'b0;

  int               mismatches = 0;
  int               idle_pct = 0;
  int               stall_left = 0;
  int               quiet_cycles = 0;
  logic [DAY_W-1:0] run_day = '0;

  energy_flow_accumulator_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic energy_t add_clipped(energy_t a, logic [63:0] b);
    logic [64:0] sum;
    sum = {17'd0, a} + {1'b0, b};
    return (sum > E_TOP) ? E_TOP[ENERGY_W-1:0] : sum[ENERGY_W-1:0];
  endfunction

  // Book one sample into the day; return 0 when it is dropped
  function automatic bit account_sample(input sample_t s, output tally_t t);
    longint      g;
    logic [63:0] gimp, pwr_red, e_imp, e_exp, e_red;
    int unsigned carry, secs;
    t = '0;
    g = s.grid;
    if (g < longint'(DROP_LIMIT) || !s.time_ok) return 1'b0;

    // Redirect power: zero at night, else measured load or load less import
    pwr_red = '0;
    if (!s.night) begin
      if (s.measured) begin
        pwr_red = 64'(s.load);
      end else begin
        gimp = (g > 0) ? g : 0;
        pwr_red = (64'(s.load) > gimp) ? 64'(s.load) - gimp : 64'd0;
      end
    end
    e_red = pwr_red * 64'(s.ivl);
    e_imp = (g > 0) ? 64'(g) * 64'(s.ivl) : 64'd0;
    e_exp = (g <= 0) ? 64'(-g) * 64'(s.ivl) : 64'd0;

    // A changed day number, or the first sample, clears the day
    t.new_day = !day_known || s.day != day_now;
    if (t.new_day) begin
      day_known = 1'b1;
      day_now = s.day;
      day_import = '0;
      day_export = '0;
      day_redirect = '0;
      day_secs = '0;
      ms_carry = 0;
      bin_live = '0;
    end
    day_import = add_clipped(day_import, e_imp);
    day_export = add_clipped(day_export, e_exp);
    day_redirect = add_clipped(day_redirect, e_red);

    // Active time: carry milliseconds, advance whole seconds
    if (s.load > thr_now) begin
      carry = ms_carry + s.ivl;
      ms_carry = carry % MS_PER_S;
      secs = day_secs + carry / MS_PER_S;
      day_secs = (secs > SECS_MAX) ? SECS_MAX : secs[SECS_W-1:0];
    end

    // Hourly bin, cleared on first touch of the day
    if (s.hour < HOURS) begin
      if (!bin_live[s.hour]) begin
        bin_imp[s.hour] = '0;
        bin_exp[s.hour] = '0;
        bin_red[s.hour] = '0;
        bin_live[s.hour] = 1'b1;
      end
      bin_imp[s.hour] = add_clipped(bin_imp[s.hour], e_imp);
      bin_exp[s.hour] = add_clipped(bin_exp[s.hour], e_exp);
      bin_red[s.hour] = add_clipped(bin_red[s.hour], e_red);
      t.hour_import = bin_imp[s.hour];
      t.hour_export = bin_exp[s.hour];
      t.hour_redirect = bin_red[s.hour];
    end
    t.import_wms = day_import;
    t.export_wms = day_export;
    t.redirect_wms = day_redirect;
    t.secs = day_secs;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_tally(input tally_t got);
    tally_t want;
    if (pending_totals.size() == 0) begin
      report_mismatch("unexpected result word, import_total", got.import_wms, 0);
      return;
    end
    want = pending_totals.pop_front();
    if (got.import_wms !== want.import_wms)
      report_mismatch("import_total", got.import_wms, want.import_wms);
    if (got.export_wms !== want.export_wms)
      report_mismatch("export_total", got.export_wms, want.export_wms);
    if (got.redirect_wms !== want.redirect_wms)
      report_mismatch("redirect_total", got.redirect_wms, want.redirect_wms);
    if (got.secs !== want.secs)
      report_mismatch("active_seconds", got.secs, want.secs);
    if (got.hour_import !== want.hour_import)
      report_mismatch("hour_import", got.hour_import, want.hour_import);
    if (got.hour_export !== want.hour_export)
      report_mismatch("hour_export", got.hour_export, want.hour_export);
    if (got.hour_redirect !== want.hour_redirect)
      report_mismatch("hour_redirect", got.hour_redirect, want.hour_redirect);
    if (got.new_day !== want.new_day)
      report_mismatch("new_day", got.new_day, want.new_day);
  endtask

  // Take result words and stall the output in random bursts
  always @(posedge clk) begin
    if (rst_n && $isunknown(out_tvalid))
      report_mismatch("unknown out_tvalid", 0, 0);
    if (rst_n && out_tvalid === 1'b1 && out_tready)
      check_tally(out_tdata);
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // End the run when no word moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one sample word, hold until taken, then maybe idle the input
  task automatic send_sample(input sample_t s);
    tally_t t;
    in_tdata  <= s;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (account_sample(s, t)) pending_totals = {pending_totals, t};
    if ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Drop the input and wait until every expected word has come back
  task automatic drain(input int cycles);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_totals.size() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] v);
    drain(8);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    thr_now = v;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic sample_t mk(int grid, int load, int ivl, bit night, bit measured,
                                 int hour, int day, bit ok);
    sample_t s;
    s = '0;
    s.grid = grid[GRID_W-1:0];
    s.load = load[LOAD_W-1:0];
    s.ivl = ivl[IVL_W-1:0];
    s.night = night;
    s.measured = measured;
    s.hour = hour[HOUR_W-1:0];
    s.day = day[DAY_W-1:0];
    s.time_ok = ok;
    return s;
  endfunction

  // Tidy samples keep the clock valid and stay on one day for a while;
  // the rest are raw bits
  function automatic sample_t pick_sample(bit tidy);
    sample_t     s;
    int          v;
    logic [31:0] r;
    s = '0;
    if (!tidy) begin
      r = $urandom;
      s.grid = r[GRID_W-1:0];
      r = $urandom;
      s.load = r[LOAD_W-1:0];
      r = $urandom;
      s.ivl = r[IVL_W-1:0];
      r = $urandom;
      s.night = r[0];
      s.measured = r[1];
      s.time_ok = r[2];
      s.hour = r[7:3];
      s.day = r[8] ? r[31:16] : run_day;
      return s;
    end
    case ($urandom_range(0, 5))
      0: v = int'($urandom_range(0, 4000)) - 2000;
      1: v = int'($urandom_range(0, 221071)) - 90000;
      2: begin
        case ($urandom_range(0, 4))
          0: v = -90000;
          1: v = 131071;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      default: v = int'($urandom_range(0, 10000)) - 5000;
    endcase
    s.grid = v[GRID_W-1:0];
    case ($urandom_range(0, 4))
      0: v = $urandom_range(0, 131071);
      1: begin
        v = int'(thr_now) + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
      end
      2: v = 0;
      default: v = $urandom_range(0, 8000);
    endcase
    s.load = v[LOAD_W-1:0];
    case ($urandom_range(0, 5))
      0: s.ivl = '0;
      1: s.ivl = IVL_W'($urandom_range(0, 65535));
      default: s.ivl = IVL_W'($urandom_range(0, 3000));
    endcase
    s.night = ($urandom_range(0, 3) == 0);
    s.measured = 1'($urandom_range(0, 1));
    s.hour = ($urandom_range(0, 9) == 0) ? HOUR_W'($urandom_range(24, 31))
                                         : HOUR_W'($urandom_range(0, 23));
    // Move to another day now and then, sometimes back to an earlier one
    if ($urandom_range(0, 59) == 0) begin
      case ($urandom_range(0, 2))
        0: run_day = DAY_W'($urandom_range(0, 65535));
        1: run_day = run_day + 1'b1;
        default: run_day = run_day - 1'b1;
      endcase
    end
    s.day = run_day;
    s.time_ok = 1'b1;
    return s;
  endfunction

  // Field extremes, each redirect branch, drops, hour range and day changes
  task automatic test_first_samples();
    idle_pct = 30;
    send_sample(mk(1000, 500, 1000, 0, 1, 0, 0, 1));
    send_sample(mk(131071, 131071, 65535, 0, 1, 23, 0, 1));
    send_sample(mk(-90000, 131071, 65535, 0, 0, 23, 0, 1));
    send_sample(mk(-90001, 5, 5, 0, 1, 0, 0, 1));
    send_sample(mk(-131072, 131071, 65535, 1, 1, 31, 65535, 1));
    send_sample(mk(500, 100, 100, 0, 0, 1, 0, 0));
    send_sample(mk(0, 10, 999, 0, 0, 2, 0, 1));
    send_sample(mk(0, 11, 999, 0, 0, 2, 0, 1));
    send_sample(mk(200, 11, 1, 0, 0, 2, 0, 1));
    send_sample(mk(100, 5000, 2000, 1, 1, 3, 0, 1));
    send_sample(mk(100, 5000, 2000, 0, 0, 3, 0, 1));
    send_sample(mk(-50, 0, 65535, 0, 0, 24, 0, 1));
    send_sample(mk(5, 20, 300, 0, 1, 31, 0, 1));
    send_sample(mk(70000, 70000, 0, 0, 1, 4, 0, 1));
    send_sample(mk(1000, 1000, 1000, 0, 1, 4, 1, 1));
    send_sample(mk(-1000, 500, 500, 0, 0, 4, 1, 1));
    send_sample(mk(100, 100, 100, 0, 1, 0, 0, 1));
    send_sample(mk(100, 100, 0, 0, 1, 5, 65535, 1));
    send_sample(mk(-1, 131071, 1, 0, 1, 0, 65535, 1));
    send_sample(mk(131071, 0, 65535, 0, 0, 23, 65535, 1));
    send_sample(mk(-90000, 1, 1, 1, 0, 22, 65535, 1));
    send_sample(mk(-100000, 1, 1, 0, 0, 0, 7, 1));
    send_sample(mk(10, 11, 1000, 0, 0, 0, 65535, 1));
    run_day = 16'd65535;
  endtask

  // Threshold at both ends of its range, loads around it
  task automatic test_threshold_extremes();
    idle_pct = 25;
    write_threshold('0);
    repeat (50) send_sample(pick_sample($urandom_range(0, 99) < 90));
    write_threshold('1);
    repeat (50) send_sample(pick_sample($urandom_range(0, 99) < 90));
  endtask

  // Long random runs over several days and thresholds
  task automatic test_random_days();
    int phase;
    for (phase = 0; phase < 6; phase++) begin
      write_threshold(phase == 5 ? THR_RESET : 16'($urandom_range(0, 3000)));
      idle_pct = (phase % 3) * 20;
      repeat (200) send_sample(pick_sample($urandom_range(0, 99) < 85));
    end
  endtask

  // Largest samples and a random mix at full rate on both sides, no idling
  task automatic test_full_rate_tail();
    int day;
    idle_pct = 0;
    write_threshold(16'd1000);
    day = int'(day_now) + 1;
    repeat (10) send_sample(mk(-90000, 131071, 65535, 0, 1, 5, day, 1));
    repeat (10) send_sample(mk(131071, 131071, 65535, 0, 0, 5, day, 1));
    send_sample(mk(131071, 131071, 777, 0, 1, 30, day, 1));
    repeat (8) send_sample(pick_sample(1'b1));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_first_samples();
    test_threshold_extremes();
    test_random_days();
    test_full_rate_tail();
    drain(24);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
